// ===== src/nsw_pkg.sv =====
// Shared constants and types for the neighbor sampler.
package nsw_pkg;

    localparam int MAX_DEGREE = 64;
    localparam int ID_WIDTH   = 32;
    localparam int ADDR_W     = $clog2(MAX_DEGREE);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int RND_W      = 31;
    localparam int SS_W       = 7;

    // Configuration register indexes
    localparam logic [0:0] CFG_PICK_LIMIT = 1'd0;
    localparam logic [0:0] CFG_CARRY_EDGE = 1'd1;

    // Commands from controller to datapath
    typedef struct packed {
        logic store_item;   // write the accepted word at fill_count
        logic clear_list;   // fill_count, overflow and step index back to zero
        logic load_step;    // read slot i and its random word at the step index
        logic start_mod;    // start remainder unit
        logic read_j;       // read slot j
        logic swap_write;   // write slot j with old slot i
        logic emit_sample;  // drive one result word
        logic emit_empty;   // drive the empty-list result
        logic next_step;    // advance step index
    } nsw_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic mod_done;
        logic shuffle;      // list longer than sample size
        logic last_step;    // current step is the last one
    } nsw_status_t;

endpackage

// ===== src/nsw_mod_unit.sv =====
// Iterative remainder unit: one quotient bit per cycle.
module nsw_mod_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [nsw_pkg::RND_W-1:0]  dividend,
    input  logic [nsw_pkg::CNT_W-1:0]  divisor,
    output logic                       done,
    output logic [nsw_pkg::CNT_W-1:0]  remainder
);
    import nsw_pkg::*;

    localparam int BIT_W = $clog2(RND_W + 1);

    logic [RND_W-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [BIT_W-1:0] bits_reg, bits_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W:0]   trial;

    // Restoring division step
    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        bits_next  = bits_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        trial      = {rem_reg, shift_reg[RND_W-1]};
        if (start)
        begin
            shift_next = dividend;
            rem_next   = '0;
            bits_next  = BIT_W'(RND_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[RND_W-2:0], 1'b0};
            // remainder stays below the divisor, so it fits CNT_W bits
            if (trial >= {1'b0, divisor})
                rem_next = CNT_W'(trial - {1'b0, divisor});
            else
                rem_next = trial[CNT_W-1:0];
            bits_next = bits_reg - 1'b1;
            if (bits_reg == BIT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bits_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            bits_reg <= bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
endmodule

// ===== src/nsw_datapath.sv =====
// Buffers, swap logic, step counter and result registers.
module nsw_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nsw_pkg::nsw_cmd_t             cmd,
    output nsw_pkg::nsw_status_t          status,
    input  logic [nsw_pkg::SS_W-1:0]      pick_limit,
    input  logic                          carry_edge_ids,
    input  logic [nsw_pkg::ID_WIDTH-1:0]  neighbor_id,
    input  logic [nsw_pkg::ID_WIDTH-1:0]  edge_id,
    input  logic [nsw_pkg::RND_W-1:0]     random_word,
    output logic                          result_valid,
    output logic [31:0]                   sampled_id,
    output logic [31:0]                   sampled_edge_id,
    output logic [6:0]                    node_sample_count,
    output logic                          run_last,
    output logic                          no_neighbors,
    output logic                          list_overflow
);
    import nsw_pkg::*;

    logic [ID_WIDTH-1:0] nbr_mem [MAX_DEGREE];
    logic [ID_WIDTH-1:0] edg_mem [MAX_DEGREE];
    logic [RND_W-1:0]    rnd_mem [MAX_DEGREE];

    logic [CNT_W-1:0]    fill_reg;
    logic                ovf_reg;
    logic [ADDR_W-1:0]   step_reg;
    logic [ADDR_W-1:0]   j_reg;
    logic [ID_WIDTH-1:0] nbr_i_reg, edg_i_reg, nbr_j_reg, edg_j_reg;
    logic [RND_W-1:0]    rnd_i_reg;
    logic [CNT_W-1:0]    ss_eff, count_k, left;
    logic [CNT_W-1:0]    rem;
    logic [CNT_W:0]      j_sum;
    logic                shuffle;
    logic                mod_done;

    logic                res_valid_reg;
    logic [31:0]         id_reg, eid_reg;
    logic [6:0]          cnt_reg;
    logic                last_reg, empty_reg, ovfo_reg;

    // Effective sample size: zero as one, saturate at the depth
    always_comb
    begin
        if (pick_limit == '0)
            ss_eff = CNT_W'(1);
        else if ({1'b0, pick_limit} > (SS_W + 1)'(MAX_DEGREE))
            ss_eff = CNT_W'(MAX_DEGREE);
        else
            ss_eff = CNT_W'(pick_limit);
    end

    assign shuffle = fill_reg > ss_eff;
    assign count_k = shuffle ? ss_eff : fill_reg;
    assign left    = fill_reg - CNT_W'(step_reg);
    assign j_sum   = {1'b0, rem} + (CNT_W + 1)'(step_reg);

    nsw_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start_mod),
        .dividend  (rnd_i_reg),
        .divisor   (left),
        .done      (mod_done),
        .remainder (rem)
    );

    assign status.mod_done  = mod_done;
    assign status.shuffle   = shuffle;
    assign status.last_step = (CNT_W'(step_reg) + 1'b1) == count_k;

    // Buffer memories: one write port, registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.store_item && fill_reg < CNT_W'(MAX_DEGREE))
        begin
            nbr_mem[fill_reg[ADDR_W-1:0]] <= neighbor_id;
            edg_mem[fill_reg[ADDR_W-1:0]] <= edge_id;
            rnd_mem[fill_reg[ADDR_W-1:0]] <= random_word;
        end
        else if (cmd.swap_write)
        begin
            nbr_mem[j_reg] <= nbr_i_reg;
            edg_mem[j_reg] <= edg_i_reg;
        end
        if (cmd.load_step)
        begin
            nbr_i_reg <= nbr_mem[step_reg];
            edg_i_reg <= edg_mem[step_reg];
            rnd_i_reg <= rnd_mem[step_reg];
        end
        if (cmd.read_j)
        begin
            nbr_j_reg <= nbr_mem[j_reg];
            edg_j_reg <= edg_mem[j_reg];
        end
        if (mod_done)
            j_reg <= (j_sum >= (CNT_W + 1)'(MAX_DEGREE)) ? step_reg : j_sum[ADDR_W-1:0];
    end

    // Fill count, overflow mark and step index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            ovf_reg  <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (cmd.clear_list)
            begin
                fill_reg <= '0;
                ovf_reg  <= 1'b0;
                step_reg <= '0;
            end
            else if (cmd.store_item)
            begin
                if (fill_reg < CNT_W'(MAX_DEGREE))
                    fill_reg <= fill_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
            else if (cmd.next_step)
                step_reg <= step_reg + 1'b1;
        end
    end

    // Result word registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= cmd.emit_sample | cmd.emit_empty;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_empty)
        begin
            id_reg    <= '0;
            eid_reg   <= '0;
            cnt_reg   <= '0;
            last_reg  <= 1'b1;
            empty_reg <= 1'b1;
            ovfo_reg  <= 1'b0;
        end
        else if (cmd.emit_sample)
        begin
            // In shuffle mode the result for step i is the old slot j
            id_reg    <= 32'(shuffle ? nbr_j_reg : nbr_i_reg);
            eid_reg   <= carry_edge_ids ? 32'(shuffle ? edg_j_reg : edg_i_reg) : '0;
            cnt_reg   <= 7'(count_k);
            last_reg  <= status.last_step;
            empty_reg <= 1'b0;
            ovfo_reg  <= ovf_reg;
        end
    end

    assign result_valid      = res_valid_reg;
    assign sampled_id        = id_reg;
    assign sampled_edge_id   = eid_reg;
    assign node_sample_count = cnt_reg;
    assign run_last          = last_reg;
    assign no_neighbors      = empty_reg;
    assign list_overflow     = ovfo_reg;
endmodule

// ===== src/nsw_ctrl.sv =====
// Controller state machine for buffering and emission.
module nsw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  list_end,
    input  logic                  list_empty,
    input  nsw_pkg::nsw_status_t  status,
    output nsw_pkg::nsw_cmd_t     cmd,
    output logic                  busy
);
    import nsw_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_READJ = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_WAIT  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (list_empty)
                    begin
                        cmd.clear_list = 1'b1;
                        cmd.emit_empty = 1'b1;
                    end
                    else
                    begin
                        cmd.store_item = 1'b1;
                        if (list_end)
                            state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load_step = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (status.shuffle)
                begin
                    cmd.start_mod = 1'b1;
                    state_next    = ST_MOD;
                end
                else
                    state_next = ST_EMIT;
            end
            ST_MOD:
            begin
                if (status.mod_done)
                    state_next = ST_READJ;
            end
            ST_READJ:
            begin
                cmd.read_j = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit_sample = 1'b1;
                cmd.swap_write  = status.shuffle;
                if (status.last_step)
                    state_next = ST_DONE;
                else
                begin
                    cmd.next_step = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            ST_DONE:
            begin
                cmd.clear_list = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = state_reg != ST_IDLE;
endmodule

// ===== src/neighbor_sampler_without_replacement_core.sv =====
// Top level of the neighbor sampler without replacement.
//
// Input: a word is taken at a rising edge with start high and busy low.
// Words without list_empty, the list_end word included, are buffered (up
// to 64, more are dropped and flagged). A word with list_empty gives a
// single result in the next cycle.
// On list_end the block turns busy and emits min(count, sample size)
// results, one per step, each with a one-cycle result_valid strobe. When
// the list fits, each step passes through LOAD, WAIT and EMIT; otherwise
// a partial Fisher-Yates step also waits in MOD on the one-bit-per-cycle
// remainder unit over the 31-bit random word, reads slot j in READJ, then
// swaps in the buffer. busy falls in the cycle after the last result.
// Config: cfg_valid/cfg_ready, cfg_index, cfg_data; cfg_ready is always
// high. The user must make writes while idle, unenforced by the block.
// Reset clears the controller, fill count and overflow mark; the sample
// size returns to 1 and edge id carrying to 0. The receiver cannot stall.
module neighbor_sampler_without_replacement_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] neighbor_id,
    input  logic [31:0] edge_id,
    input  logic [30:0] random_word,
    input  logic        list_end,
    input  logic        list_empty,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    output logic        result_valid,
    output logic [31:0] sampled_id,
    output logic [31:0] sampled_edge_id,
    output logic [6:0]  node_sample_count,
    output logic        run_last,
    output logic        no_neighbors,
    output logic        list_overflow
);
    import nsw_pkg::*;

    nsw_cmd_t    cmd;
    nsw_status_t status;
    logic [SS_W-1:0] pick_limit_reg;
    logic            carry_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_limit_reg <= SS_W'(1);
            carry_reg      <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PICK_LIMIT: pick_limit_reg <= cfg_data;
                CFG_CARRY_EDGE: carry_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    nsw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .list_end   (list_end),
        .list_empty (list_empty),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy)
    );

    nsw_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .pick_limit        (pick_limit_reg),
        .carry_edge_ids    (carry_reg),
        .neighbor_id       (neighbor_id),
        .edge_id           (edge_id),
        .random_word       (random_word),
        .result_valid      (result_valid),
        .sampled_id        (sampled_id),
        .sampled_edge_id   (sampled_edge_id),
        .node_sample_count (node_sample_count),
        .run_last          (run_last),
        .no_neighbors      (no_neighbors),
        .list_overflow     (list_overflow)
    );

    // An empty-list result is always the last of its node
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && no_neighbors |-> run_last && node_sample_count == 7'd0)
        else $error("empty result not final");

    // Commands that write the buffer never coincide
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.store_item && cmd.swap_write))
        else $error("buffer write conflict");

    // An empty-list word gives a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && list_empty |=> result_valid && no_neighbors)
        else $error("empty result missing");
endmodule
